### design/irfe_pkg.sv
// ----------------------------------------------------------------------------
// IR frame encoder package
// Shared types, codes and frame timing constants for the IR frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irfe_pkg;

	// Operation codes of an input item.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Protocol codes.
	localparam logic [1:0] PROTO_NEC     = 2'd0;
	localparam logic [1:0] PROTO_SONY    = 2'd1;
	localparam logic [1:0] PROTO_SAMSUNG = 2'd2;
	localparam logic [1:0] PROTO_LG      = 2'd3;

	// Status codes of a result.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
	localparam logic [1:0] STATUS_BUSY    = 2'd2;

	// Carrier half period after reset.
	localparam logic [7:0] CARRIER_HALF_RESET = 8'd13;

	// Queue depths.
	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	// Durations in microsecond ticks.
	localparam logic [15:0] T_NEC_LEAD_MARK  = 16'd9000;
	localparam logic [15:0] T_NEC_LEAD_SPACE = 16'd4500;
	localparam logic [15:0] T_NEC_ONE_SPACE  = 16'd1690;
	localparam logic [15:0] T_NEC_UNIT       = 16'd560;
	localparam logic [15:0] T_NEC_GAP        = 16'd40000;
	localparam logic [15:0] T_SAM_LEAD_MARK  = 16'd4500;
	localparam logic [15:0] T_SONY_LEAD_MARK = 16'd2400;
	localparam logic [15:0] T_SONY_ONE_MARK  = 16'd1200;
	localparam logic [15:0] T_SONY_UNIT      = 16'd600;
	localparam logic [15:0] T_SONY_GAP       = 16'd45000;
	localparam logic [15:0] T_LG_LEAD_MARK   = 16'd8500;
	localparam logic [15:0] T_LG_LEAD_SPACE  = 16'd4250;
	localparam logic [15:0] T_LG_ONE_SPACE   = 16'd1590;
	localparam logic [15:0] T_LG_UNIT        = 16'd530;
	localparam logic [15:0] T_LG_GAP         = 16'd60000;

	// Payload bit counts.
	localparam logic [5:0] BITS_SONY = 6'd12;
	localparam logic [5:0] BITS_LG   = 6'd28;
	localparam logic [5:0] BITS_STD  = 6'd32;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic        is_start;
		logic        proto_ok;
		logic [1:0]  proto;
		logic [31:0] payload;
		logic [7:0]  frames;
	} item_t;

	// One result.
	typedef struct packed {
		logic       ir_out;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

### design/irfe_front.sv
// ----------------------------------------------------------------------------
// IR frame encoder front end
// Accepts input items, builds the frame payload of a start and queues the
// classified items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_front #(
	parameter int MID_DEPTH = irfe_pkg::MID_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic                operation,
	input  wire logic [2:0]          protocol,
	input  wire logic [7:0]          address,
	input  wire logic [15:0]         command,
	input  wire logic [7:0]          repeat_req,
	output logic                     mid_valid,
	output irfe_pkg::item_t          mid_item,
	input  wire logic                mid_pop
);

	localparam int PTR_W = $clog2(MID_DEPTH);
	localparam int CNT_W = $clog2(MID_DEPTH + 1);

	irfe_pkg::item_t mem_q [MID_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	irfe_pkg::item_t item_d;
	logic [7:0]      lo;
	logic [3:0]      chk;
	logic            enq, deq;

	always_comb begin
		lo  = command[7:0];
		chk = command[15:12] + command[11:8] + command[7:4] + command[3:0];
		item_d.is_start = (operation == irfe_pkg::OP_START);
		item_d.proto_ok = (protocol <= {1'b0, irfe_pkg::PROTO_LG});
		item_d.proto    = protocol[1:0];
		case (protocol[1:0])
			irfe_pkg::PROTO_NEC: begin
				item_d.payload = {~lo, lo, ~address, address};
			end
			irfe_pkg::PROTO_SAMSUNG: begin
				item_d.payload = {~lo, lo, address, address};
			end
			irfe_pkg::PROTO_SONY: begin
				item_d.payload = {20'd0, address[4:0], command[6:0]};
			end
			default: begin
				item_d.payload = {4'd0, address, command, chk};
			end
		endcase
		// A repeat count of zero selects the protocol default.
		if (repeat_req == 8'd0) begin
			item_d.frames = (protocol[1:0] == irfe_pkg::PROTO_SONY) ? 8'd3 : 8'd1;
		end else begin
			item_d.frames = repeat_req;
		end
	end

	assign full      = (count_q == CNT_W'(MID_DEPTH));
	assign mid_valid = (count_q != '0);
	assign mid_item  = mem_q[rd_ptr_q];
	assign enq       = push && !full;
	assign deq       = mid_pop && mid_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/irfe_back.sv
// ----------------------------------------------------------------------------
// IR frame encoder back end
// Runs the frame sequencer and carrier generator one item per cycle while the
// result queue has room, and queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_back #(
	parameter int OUT_DEPTH = irfe_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [7:0]          cfg_wr_data,
	input  wire logic                mid_valid,
	input  wire irfe_pkg::item_t     mid_item,
	output logic                     mid_pop,
	output logic                     empty,
	input  wire logic                pop,
	output irfe_pkg::result_t        head
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD_MARK,
		PH_LEAD_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE,
		PH_STOP_MARK,
		PH_GAP
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  proto_q, proto_n;
	logic [31:0] payload_q, payload_n;
	logic [5:0]  pos_q, pos_n;
	logic [7:0]  frames_q, frames_n;
	logic [15:0] dur_q, dur_n;
	logic [7:0]  cc_q, cc_n;
	logic        lvl_q, lvl_n;
	logic [7:0]  chp_q;

	irfe_pkg::result_t res;
	irfe_pkg::result_t out_mem_q [OUT_DEPTH];
	logic [PTR_W-1:0]  out_wr_q, out_rd_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic        step, out_deq;
	logic [7:0]  half, cc_inc;
	logic [15:0] dur_dec;
	logic [5:0]  pos_inc, nbits;
	logic [7:0]  frames_dec;
	logic        entered;

	function automatic logic is_mark(input phase_t ph);
		return (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
	endfunction

	// LG sends its payload most significant bit first, the others the other way.
	function automatic logic bit_at(input logic [31:0] pl, input logic [1:0] pr,
		input logic [5:0] pos);
		logic [4:0] idx;
		idx = (pr == irfe_pkg::PROTO_LG) ? 5'd27 - pos[4:0] : pos[4:0];
		return pl[idx];
	endfunction

	function automatic logic [15:0] lead_mark(input logic [1:0] pr);
		case (pr)
			irfe_pkg::PROTO_NEC:     lead_mark = irfe_pkg::T_NEC_LEAD_MARK;
			irfe_pkg::PROTO_SONY:    lead_mark = irfe_pkg::T_SONY_LEAD_MARK;
			irfe_pkg::PROTO_SAMSUNG: lead_mark = irfe_pkg::T_SAM_LEAD_MARK;
			default:                 lead_mark = irfe_pkg::T_LG_LEAD_MARK;
		endcase
	endfunction

	function automatic logic [15:0] bit_mark(input logic [1:0] pr, input logic b);
		if (pr == irfe_pkg::PROTO_SONY) begin
			bit_mark = b ? irfe_pkg::T_SONY_ONE_MARK : irfe_pkg::T_SONY_UNIT;
		end else if (pr == irfe_pkg::PROTO_LG) begin
			bit_mark = irfe_pkg::T_LG_UNIT;
		end else begin
			bit_mark = irfe_pkg::T_NEC_UNIT;
		end
	endfunction

	assign step    = mid_valid && (out_cnt_q < CNT_W'(OUT_DEPTH));
	assign mid_pop = step;
	assign empty   = (out_cnt_q == '0);
	assign head    = out_mem_q[out_rd_q];
	assign out_deq = pop && !empty;

	always_comb begin
		half       = (chp_q == 8'd0) ? 8'd1 : chp_q;
		cc_inc     = (cc_q == 8'd255) ? cc_q : cc_q + 8'd1;
		dur_dec    = (dur_q == 16'd0) ? 16'd0 : dur_q - 16'd1;
		pos_inc    = pos_q + 6'd1;
		frames_dec = (frames_q == 8'd0) ? 8'd0 : frames_q - 8'd1;
		case (proto_q)
			irfe_pkg::PROTO_SONY: nbits = irfe_pkg::BITS_SONY;
			irfe_pkg::PROTO_LG:   nbits = irfe_pkg::BITS_LG;
			default:              nbits = irfe_pkg::BITS_STD;
		endcase

		phase_n   = phase_q;
		proto_n   = proto_q;
		payload_n = payload_q;
		pos_n     = pos_q;
		frames_n  = frames_q;
		dur_n     = dur_q;
		cc_n      = cc_q;
		lvl_n     = lvl_q;
		entered   = 1'b0;
		res       = '0;
		res.status = irfe_pkg::STATUS_OK;

		if (mid_item.is_start) begin
			if (phase_q != PH_IDLE) begin
				res.status   = irfe_pkg::STATUS_BUSY;
				res.busy_res = 1'b1;
			end else if (!mid_item.proto_ok) begin
				res.status = irfe_pkg::STATUS_UNKNOWN;
			end else begin
				proto_n      = mid_item.proto;
				payload_n    = mid_item.payload;
				frames_n     = mid_item.frames;
				pos_n        = 6'd0;
				phase_n      = PH_LEAD_MARK;
				dur_n        = lead_mark(mid_item.proto);
				entered      = 1'b1;
				res.busy_res = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			res.busy_res = 1'b1;
			if (is_mark(phase_q)) begin
				res.ir_out = lvl_q;
				if (cc_inc >= half) begin
					cc_n  = 8'd0;
					lvl_n = ~lvl_q;
				end else begin
					cc_n = cc_inc;
				end
			end
			dur_n = dur_dec;
			if (dur_dec == 16'd0) begin
				entered = 1'b1;
				case (phase_q)
					PH_LEAD_MARK: begin
						phase_n = PH_LEAD_SPACE;
						if (proto_q == irfe_pkg::PROTO_SONY) begin
							dur_n = irfe_pkg::T_SONY_UNIT;
						end else if (proto_q == irfe_pkg::PROTO_LG) begin
							dur_n = irfe_pkg::T_LG_LEAD_SPACE;
						end else begin
							dur_n = irfe_pkg::T_NEC_LEAD_SPACE;
						end
					end
					PH_LEAD_SPACE: begin
						pos_n   = 6'd0;
						phase_n = PH_BIT_MARK;
						dur_n   = bit_mark(proto_q, bit_at(payload_q, proto_q, 6'd0));
					end
					PH_BIT_MARK: begin
						phase_n = PH_BIT_SPACE;
						if (proto_q == irfe_pkg::PROTO_SONY) begin
							dur_n = irfe_pkg::T_SONY_UNIT;
						end else if (proto_q == irfe_pkg::PROTO_LG) begin
							dur_n = bit_at(payload_q, proto_q, pos_q) ?
								irfe_pkg::T_LG_ONE_SPACE : irfe_pkg::T_LG_UNIT;
						end else begin
							dur_n = bit_at(payload_q, proto_q, pos_q) ?
								irfe_pkg::T_NEC_ONE_SPACE : irfe_pkg::T_NEC_UNIT;
						end
					end
					PH_BIT_SPACE: begin
						pos_n = pos_inc;
						if (pos_inc < nbits) begin
							phase_n = PH_BIT_MARK;
							dur_n   = bit_mark(proto_q, bit_at(payload_q, proto_q, pos_inc));
						end else if (proto_q == irfe_pkg::PROTO_SONY) begin
							phase_n = PH_GAP;
							dur_n   = irfe_pkg::T_SONY_GAP;
						end else begin
							phase_n = PH_STOP_MARK;
							dur_n   = (proto_q == irfe_pkg::PROTO_LG) ?
								irfe_pkg::T_LG_UNIT : irfe_pkg::T_NEC_UNIT;
						end
					end
					PH_STOP_MARK: begin
						phase_n = PH_GAP;
						dur_n   = (proto_q == irfe_pkg::PROTO_LG) ?
							irfe_pkg::T_LG_GAP : irfe_pkg::T_NEC_GAP;
					end
					default: begin
						frames_n = frames_dec;
						if (frames_dec != 8'd0) begin
							phase_n = PH_LEAD_MARK;
							dur_n   = lead_mark(proto_q);
						end else begin
							phase_n      = PH_IDLE;
							dur_n        = 16'd0;
							res.done_res = 1'b1;
						end
					end
				endcase
			end
		end

		// Every new phase restarts the carrier, high for a mark and low otherwise.
		if (entered) begin
			cc_n  = 8'd0;
			lvl_n = is_mark(phase_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			proto_q   <= irfe_pkg::PROTO_NEC;
			payload_q <= '0;
			pos_q     <= '0;
			frames_q  <= '0;
			dur_q     <= '0;
			cc_q      <= '0;
			lvl_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			proto_q   <= proto_n;
			payload_q <= payload_n;
			pos_q     <= pos_n;
			frames_q  <= frames_n;
			dur_q     <= dur_n;
			cc_q      <= cc_n;
			lvl_q     <= lvl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chp_q <= irfe_pkg::CARRIER_HALF_RESET;
		end else if (cfg_wr_en) begin
			chp_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (step) begin
				out_wr_q <= (out_wr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
			end
			if (out_deq) begin
				out_rd_q <= (out_rd_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
			end
			if (step && !out_deq) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_deq && !step) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/ir_remote_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// IR remote frame encoder
// Encodes NEC, Sony 12-bit, Samsung and LG frames into a carrier-modulated
// emitter level, one level per microsecond tick.
// ----------------------------------------------------------------------------
// Usage:
// Items enter through a queue-like port: a transaction completes when push is
// high and full is low. Each item is a start command or a one-microsecond
// tick, and each gives exactly one result. Results leave through a second
// queue-like port: the oldest result is shown while empty is low and is taken
// when pop is high. The carrier half period is written through cfg_wr_en and
// cfg_wr_data, by the user only while idle; the block does not enforce it.
// A front end builds the payload of a start and queues classified items; the
// back end runs the frame sequencer and carrier counter, one item per cycle
// while the result queue has room, into a small result queue. An accepted item
// waits in the front queue and its result in the result queue; the sustained
// rate is one item per cycle while the receiver keeps popping.
// When the receiver stops popping, the result queue fills, the back end
// halts, and then the front queue fills and raises full; nothing is lost.
// Reset empties both queues, returns the sequencer to idle and sets the half
// period to 13 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_frame_encoder_unit #(
	parameter int MID_DEPTH = irfe_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = irfe_pkg::OUT_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic        operation,
	input  wire logic [2:0]  protocol,
	input  wire logic [7:0]  address,
	input  wire logic [15:0] command,
	input  wire logic [7:0]  repeat_req,
	output logic             empty,
	input  wire logic        pop,
	output logic             ir_out,
	output logic             busy_res,
	output logic             done_res,
	output logic [1:0]       status
);

	irfe_pkg::item_t   mid_item;
	irfe_pkg::result_t head;
	logic              mid_valid, mid_pop;

	irfe_front #(
		.MID_DEPTH(MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.protocol  (protocol),
		.address   (address),
		.command   (command),
		.repeat_req(repeat_req),
		.mid_valid (mid_valid),
		.mid_item  (mid_item),
		.mid_pop   (mid_pop)
	);

	irfe_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mid_valid  (mid_valid),
		.mid_item   (mid_item),
		.mid_pop    (mid_pop),
		.empty      (empty),
		.pop        (pop),
		.head       (head)
	);

	assign ir_out   = head.ir_out;
	assign busy_res = head.busy_res;
	assign done_res = head.done_res;
	assign status   = head.status;

endmodule

`default_nettype wire

### design/irfe_checker.sv
// ----------------------------------------------------------------------------
// IR frame encoder port checker
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       ir_out,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [1:0] status
);

	// The result queue is empty once reset has been applied at an edge.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty during reset");

	// The last tick of a transmission is a plain idle-level tick of a busy block.
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> (busy_res && !ir_out && status == irfe_pkg::STATUS_OK))
		else $error("done result with inconsistent fields");

	// A rejected start leaves the block idle, an ignored start finds it busy.
	a_status_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == irfe_pkg::STATUS_UNKNOWN) |-> !busy_res &&
		!ir_out && !done_res)
		else $error("rejected start reports activity");

	a_ignored_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == irfe_pkg::STATUS_BUSY || ir_out)) |-> busy_res)
		else $error("output activity while not busy");

	// A result that is not taken stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({ir_out, busy_res, done_res, status})))
		else $error("waiting result changed");

endmodule

bind ir_remote_frame_encoder_unit irfe_checker u_irfe_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.empty   (empty),
	.pop     (pop),
	.ir_out  (ir_out),
	.busy_res(busy_res),
	.done_res(done_res),
	.status  (status)
);

`default_nettype wire
